// File: rtl/sfrs_pkg.sv
// Shared types and constants for the serial frame receiver / scaler.
// Covers status codes, framing constants, queue entry layout and the fixed-point scaling constants.
// No dependencies.
`timescale 1ns / 1ps

package sfrs_pkg;

  // Result status codes. ST_CHAN also tags a good power frame in the queue.
  typedef enum logic [2:0] {
    ST_RECORD  = 3'd0,
    ST_END     = 3'd1,
    ST_CHAN    = 3'd2,
    ST_BAD     = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  // Framing modes of the message kind register
  localparam logic [7:0] KIND_RECORD = 8'd1;
  localparam logic [7:0] KIND_POWER  = 8'd2;

  // Record stream framing
  localparam logic [4:0]  RECORD_LEN = 5'd6;
  localparam logic [4:0]  END_POS    = 5'd3;
  localparam logic [23:0] END_MARK   = 24'hFFDDFF;

  // Power frame framing
  localparam logic [4:0] FRAME_LEN   = 5'd17;
  localparam logic [4:0] CHECK_POS   = 5'd16;
  localparam logic [4:0] PAYLOAD_POS = 5'd2;
  localparam logic [7:0] HDR_BYTE0   = 8'h54;
  localparam logic [7:0] HDR_BYTE1   = 8'h01;
  localparam int         PAYLOAD_LEN = 14;
  localparam int         PAYLOAD_W   = PAYLOAD_LEN * 8;

  // Channels per good frame; channels below BIG_CHANS get the x3 factor
  localparam logic [2:0] LAST_CHAN = 3'd6;
  localparam logic [2:0] BIG_CHANS = 3'd4;

  // Default depth of the front/back queue
  localparam int QUEUE_DEPTH = 4;

  // volts_fixed = round(2^24 * m * d / 102375) with d = 2*raw - 4095.
  // m = 3 reduces to a divide by 34125, m = 1 to a divide by 102375.
  localparam logic signed [17:0] RAW_OFFSET = 18'sd4095;
  localparam logic [17:0] DIV_M3  = 18'd34125;
  localparam logic [17:0] DIV_M1  = 18'd102375;
  localparam int          REC_SH  = 20;
  localparam logic [28:0] REC_M3  = 29'((64'd1 << (24 + REC_SH)) / 64'd34125);
  localparam logic [28:0] REC_M1  = 29'((64'd1 << (24 + REC_SH)) / 64'd102375);
  localparam logic [17:0] HALF_M3 = 18'((34125 + 1) / 2);
  localparam logic [17:0] HALF_M1 = 18'((102375 + 1) / 2);
  localparam logic [17:0] TRI_M3  = 18'((3 * 34125 + 1) / 2);
  localparam logic [17:0] TRI_M1  = 18'((3 * 102375 + 1) / 2);

  // One command from the framer to the result engine
  typedef struct packed {
    status_t                op;
    logic [PAYLOAD_W-1:0]   data;   // record in [47:0], or frame bytes 2..15
  } q_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  // Side fields carried along the scaling pipeline
  typedef struct packed {
    status_t     status;
    logic [47:0] word;
    logic [2:0]  channel;
    logic        last;
    logic        neg;
    logic        big;
  } meta_t;

endpackage

// File: rtl/sfrs_front.sv
// Front end: message kind register, byte framing, header and checksum checks.
// Pushes one command per completed record, end marker, frame or rejected byte. Uses sfrs_pkg.
`timescale 1ns / 1ps

module sfrs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_message_kind,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  sfrs_pkg::q_status_t  q_st,
  output logic                 push,
  output sfrs_pkg::q_entry_t   push_entry
);
  import sfrs_pkg::*;

  logic [7:0]  kind_r, kind_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [47:0] shift_r, shift_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic        hdr_r, hdr_nxt;
  logic [7:0]  payload_r [PAYLOAD_LEN];

  logic        accept;
  logic        pl_we;
  logic [3:0]  pl_idx;
  logic [4:0]  base_pos;
  logic [47:0] base_shift;
  logic [7:0]  base_xor;
  logic        base_hdr;
  logic [47:0] sh;
  logic [4:0]  pos_inc;
  logic [PAYLOAD_W-1:0] payload_vec;

  // a register write takes the cycle, so no byte is taken alongside it
  assign in_ready = !q_st.full && !cfg_we;
  assign accept   = in_valid && in_ready;

  // Frame bytes 2..15 packed first byte most significant
  always_comb begin
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      payload_vec[PAYLOAD_W-1-8*i -: 8] = payload_r[i];
    end
  end

  // Framing next state and command generation
  always_comb begin
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    shift_nxt  = shift_r;
    xor_nxt    = xor_r;
    hdr_nxt    = hdr_r;
    push       = 1'b0;
    push_entry = '{op: ST_UNKNOWN, data: '0};
    pl_we      = 1'b0;
    pl_idx     = '0;
    base_pos   = pos_r;
    base_shift = shift_r;
    base_xor   = xor_r;
    base_hdr   = hdr_r;
    sh         = '0;
    pos_inc    = '0;

    if (cfg_we) begin
      // register write restarts framing
      kind_nxt  = cfg_message_kind;
      pos_nxt   = '0;
      shift_nxt = '0;
      xor_nxt   = '0;
      hdr_nxt   = 1'b1;
    end else if (accept) begin
      priority if (kind_r == KIND_RECORD) begin
        if (pos_r >= RECORD_LEN) begin
          base_pos   = '0;
          base_shift = '0;
        end
        sh      = {base_shift[39:0], in_rx_byte};
        pos_inc = base_pos + 5'd1;
        if (pos_inc == END_POS && sh[23:0] == END_MARK) begin
          // end-of-run marker replaces the record
          pos_nxt    = '0;
          shift_nxt  = '0;
          xor_nxt    = '0;
          hdr_nxt    = 1'b1;
          push       = 1'b1;
          push_entry = '{op: ST_END, data: '0};
        end else if (pos_inc == RECORD_LEN) begin
          pos_nxt    = '0;
          shift_nxt  = sh;
          push       = 1'b1;
          push_entry = '{op: ST_RECORD, data: PAYLOAD_W'(sh)};
        end else begin
          pos_nxt   = pos_inc;
          shift_nxt = sh;
        end
      end else if (kind_r == KIND_POWER) begin
        if (pos_r >= FRAME_LEN) begin
          base_pos = '0;
          base_xor = '0;
          base_hdr = 1'b1;
        end
        if (base_pos < CHECK_POS) begin
          hdr_nxt = base_hdr;
          if (base_pos == 5'd0 && in_rx_byte != HDR_BYTE0) hdr_nxt = 1'b0;
          if (base_pos == 5'd1 && in_rx_byte != HDR_BYTE1) hdr_nxt = 1'b0;
          if (base_pos >= PAYLOAD_POS) begin
            pl_we  = 1'b1;
            pl_idx = 4'(base_pos - PAYLOAD_POS);
          end
          xor_nxt = base_xor ^ in_rx_byte;
          pos_nxt = base_pos + 5'd1;
        end else begin
          // checksum byte: close the frame
          pos_nxt   = '0;
          shift_nxt = '0;
          xor_nxt   = '0;
          hdr_nxt   = 1'b1;
          push      = 1'b1;
          if (base_hdr && base_xor == in_rx_byte) begin
            push_entry = '{op: ST_CHAN, data: payload_vec};
          end else begin
            push_entry = '{op: ST_BAD, data: '0};
          end
        end
      end else begin
        push       = 1'b1;
        push_entry = '{op: ST_UNKNOWN, data: '0};
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= '0;
      pos_r   <= '0;
      shift_r <= '0;
      xor_r   <= '0;
      hdr_r   <= 1'b1;
    end else begin
      kind_r  <= kind_nxt;
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      xor_r   <= xor_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

  // Frame payload bytes, written before every read
  always_ff @(posedge clk) begin
    if (pl_we) begin
      payload_r[pl_idx] <= in_rx_byte;
    end
  end

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < FRAME_LEN) else $error("frame position past frame length");

  a_record_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == KIND_RECORD) |-> (pos_r < RECORD_LEN))
    else $error("record position past record length");

endmodule

// File: rtl/sfrs_queue.sv
// Short command queue between the framer and the result engine.
// Register array with wrap-around pointers. Uses sfrs_pkg.
`timescale 1ns / 1ps

module sfrs_queue #(
  parameter int DEPTH = sfrs_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sfrs_pkg::q_entry_t   push_entry,
  input  logic                 pop,
  output sfrs_pkg::q_entry_t   head,
  output sfrs_pkg::q_status_t  st
);
  import sfrs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t          mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign st.not_empty = (cnt_r != '0);
  assign st.full      = (cnt_r == CNT_W'(DEPTH));

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && st.full && !pop)) else $error("queue write while full");

endmodule

// File: rtl/sfrs_back.sv
// Result engine: expands queued commands into results, scales power channels
// through a three-stage reciprocal-multiply pipeline into an output register.
// Uses sfrs_pkg.
`timescale 1ns / 1ps

module sfrs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfrs_pkg::q_status_t  q_st,
  input  sfrs_pkg::q_entry_t   q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [47:0]          out_record_word,
  output logic [2:0]           out_channel,
  output logic signed [26:0]   out_volts_fixed,
  output logic                 out_last
);
  import sfrs_pkg::*;

  logic        adv, issue, is_frame;
  logic [2:0]  ch_r, ch_nxt;
  logic [6:0]  raw_lsb;
  logic [15:0] raw;
  logic signed [17:0] d;
  meta_t       m0;
  logic [16:0] mag0;

  // stage registers
  logic        s0_v_r, s1_v_r, s2_v_r, out_v_r;
  meta_t       s0_m_r, s1_m_r, s2_m_r, out_m_r;
  logic [16:0] s0_mag_r;
  logic [25:0] s1_q_r, s2_q_r;
  logic [17:0] s2_rem_r;
  logic signed [26:0] out_volts_r;

  logic [45:0] prod1;
  logic [35:0] prod2;
  logic [17:0] rem;
  logic [1:0]  inc;
  logic [26:0] qr;
  logic signed [26:0] volts;

  // Whole pipeline moves when the output register can take a new result
  assign adv      = !out_v_r || out_ready;
  assign issue    = adv && q_st.not_empty;
  assign is_frame = (q_head.op == ST_CHAN);
  assign q_pop    = issue && (!is_frame || ch_r == LAST_CHAN);

  // Issue: pick channel word, offset to signed d, split sign and magnitude
  assign raw_lsb = {3'(3'd6 - ch_r), 4'd0};
  assign raw     = q_head.data[raw_lsb +: 16];
  assign d       = $signed({1'b0, raw, 1'b0}) - RAW_OFFSET;

  always_comb begin
    ch_nxt = ch_r;
    if (issue && is_frame) begin
      ch_nxt = (ch_r == LAST_CHAN) ? 3'd0 : ch_r + 3'd1;
    end
    m0.status  = q_head.op;
    m0.word    = (q_head.op == ST_RECORD) ? q_head.data[47:0] : 48'd0;
    m0.channel = is_frame ? ch_r : 3'd0;
    m0.last    = !is_frame || (ch_r == LAST_CHAN);
    m0.neg     = d[17];
    m0.big     = (ch_r < BIG_CHANS);
    mag0       = 17'(d[17] ? -d : d);
  end

  // Stage 1: quotient estimate by reciprocal multiply
  assign prod1 = 46'(s0_mag_r) * 46'(s0_m_r.big ? REC_M3 : REC_M1);

  // Stage 2: remainder, only its low bits are needed since it stays below 2*div
  assign prod2 = 36'(s1_q_r[17:0]) * 36'(s1_m_r.big ? DIV_M3 : DIV_M1);
  assign rem   = 18'd0 - prod2[17:0];

  // Stage 3: correct estimate and round to nearest, then apply sign
  always_comb begin
    inc = 2'(s2_rem_r >= (s2_m_r.big ? HALF_M3 : HALF_M1))
        + 2'(s2_rem_r >= (s2_m_r.big ? TRI_M3 : TRI_M1));
    qr  = 27'(s2_q_r) + 27'(inc);
    if (s2_m_r.status != ST_CHAN) begin
      volts = '0;
    end else if (s2_m_r.neg) begin
      volts = -$signed(qr);
    end else begin
      volts = $signed(qr);
    end
  end

  // Valid bits and channel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r    <= '0;
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      ch_r <= ch_nxt;
      if (adv) begin
        s0_v_r  <= issue;
        s1_v_r  <= s0_v_r;
        s2_v_r  <= s1_v_r;
        out_v_r <= s2_v_r;
      end
    end
  end

  // Pipeline data
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_m_r      <= m0;
      s0_mag_r    <= mag0;
      s1_m_r      <= s0_m_r;
      s1_q_r      <= prod1[45:20];
      s2_m_r      <= s1_m_r;
      s2_q_r      <= s1_q_r;
      s2_rem_r    <= rem;
      out_m_r     <= s2_m_r;
      out_volts_r <= volts;
    end
  end

  assign out_valid       = out_v_r;
  assign out_status      = out_m_r.status;
  assign out_record_word = out_m_r.word;
  assign out_channel     = out_m_r.channel;
  assign out_volts_fixed = out_volts_r;
  assign out_last        = out_m_r.last;

  a_chan_only_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (ch_r != 3'd0) |-> (q_st.not_empty && q_head.op == ST_CHAN))
    else $error("channel counter running without a frame at queue head");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_m_r.last == (out_m_r.status != ST_CHAN ||
                                  out_m_r.channel == LAST_CHAN)))
    else $error("last flag does not match result kind");

endmodule

// File: rtl/serial_frame_receiver_scaler.sv
// Serial frame receiver and scaler: one byte per cycle in while in_ready is high, records or channels out.
// Path from byte transfer to result: through queue, 3 scaling stages, output reg.
// Throughput: one byte per cycle while in_ready; one result per cycle while out_ready, a good frame gives 7 in a row.
// The command queue (QUEUE_DEPTH entries) absorbs output stalls; in_ready drops when full.
// Reset (rst_n, synchronous) clears message kind to 0, framing state and all valid bits.
`timescale 1ns / 1ps

module serial_frame_receiver_scaler #(
  parameter int QUEUE_DEPTH = sfrs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_message_kind,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [47:0]        out_record_word,
  output logic [2:0]         out_channel,
  output logic signed [26:0] out_volts_fixed,
  output logic               out_last
);
  import sfrs_pkg::*;

  q_status_t q_st;
  q_entry_t  push_entry, q_head;
  logic      push, q_pop;

  sfrs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_message_kind (cfg_message_kind),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .q_st             (q_st),
    .push             (push),
    .push_entry       (push_entry)
  );

  sfrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .st         (q_st)
  );

  sfrs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_st            (q_st),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_record_word (out_record_word),
    .out_channel     (out_channel),
    .out_volts_fixed (out_volts_fixed),
    .out_last        (out_last)
  );

endmodule

// File: bench/tb_serial_frame_receiver_scaler.sv
// Self-checking bench for serial_frame_receiver_scaler: record stream, power frames, odd kinds.
// A queue-fed driver and a clocked monitor with a built-in framing/scaling predictor.
// Depends on rtl/sfrs_pkg.sv and rtl/serial_frame_receiver_scaler.sv.
`timescale 1ns / 1ps

module tb_serial_frame_receiver_scaler;
  import sfrs_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RX_HOLD_CYCLES = 150;
  localparam int unsigned TAIL_CYCLES    = 12;
  localparam int unsigned CYCLE_LIMIT    = 200000;

  typedef enum {JOB_BYTE, JOB_KIND, JOB_DRAIN} job_kind_t;
  typedef enum {FLAW_NONE, FLAW_HDR0, FLAW_HDR1, FLAW_SUM} frame_flaw_t;

  typedef struct {
    job_kind_t   job;
    logic [7:0]  data;
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          hold;
  } job_t;

  typedef struct packed {
    status_t            status;
    logic [47:0]        word;
    logic [2:0]         channel;
    logic signed [26:0] volts;
    logic               last;
  } result_t;

  logic               clk;
  logic               rst_n            = 1'b0;
  logic               cfg_we           = 1'b0;
  logic [7:0]         cfg_message_kind = 8'd0;
  logic               in_valid         = 1'b0;
  logic               in_ready;
  logic [7:0]         in_rx_byte       = 8'd0;
  logic               out_valid;
  logic               out_ready        = 1'b0;
  logic [2:0]         out_status;
  logic [47:0]        out_record_word;
  logic [2:0]         out_channel;
  logic signed [26:0] out_volts_fixed;
  logic               out_last;

  serial_frame_receiver_scaler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_message_kind (cfg_message_kind),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_record_word  (out_record_word),
    .out_channel      (out_channel),
    .out_volts_fixed  (out_volts_fixed),
    .out_last         (out_last)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  job_t        jobs[$];
  result_t     pending_results[$];
  int unsigned n_offered     = 0;
  int unsigned n_taken       = 0;
  int unsigned settle_count  = 0;
  int unsigned n_errors      = 0;
  int unsigned cur_stall     = 0;
  int unsigned hold_req      = 0;
  int unsigned gen_gap       = 0;
  int unsigned gen_stall     = 0;
  bit          gen_hold      = 1'b0;

  // Predictor state
  logic [7:0]  kind_reg;
  logic [4:0]  frame_pos;
  logic [47:0] record_bytes;
  logic [7:0]  frame_xor;
  bit          header_good;
  logic [7:0]  frame_payload [PAYLOAD_LEN];

  task automatic restart_framing();
    frame_pos    = '0;
    record_bytes = '0;
    frame_xor    = '0;
    header_good  = 1'b1;
  endtask

  task automatic emit(input status_t st, input logic [47:0] word, input logic [2:0] chan,
                      input logic signed [26:0] volts, input logic last);
    pending_results.push_back('{status: st, word: word, channel: chan, volts: volts,
                                last: last});
  endtask

  // round((512*raw - 1048320) * m * 65536 / 102375), ties away from zero
  function automatic logic signed [26:0] volts_of(input logic [15:0] raw, input bit big);
    longint num, mag, q;
    num = (longint'(raw) * 512 - 64'sd1048320) * (big ? 3 : 1) * 65536;
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + 102375) / 204750;
    return 27'((num < 0) ? -q : q);
  endfunction

  // Frame one received byte and queue the results it causes
  task automatic frame_byte(input logic [7:0] b);
    bit good;
    if (kind_reg == KIND_RECORD) begin
      if (frame_pos >= RECORD_LEN) restart_framing();
      record_bytes = {record_bytes[39:0], b};
      frame_pos    = frame_pos + 5'd1;
      if (frame_pos == END_POS && record_bytes[23:0] == END_MARK) begin
        restart_framing();
        emit(ST_END, '0, '0, '0, 1'b1);
      end else if (frame_pos == RECORD_LEN) begin
        emit(ST_RECORD, record_bytes, '0, '0, 1'b1);
        frame_pos = '0;
      end
    end else if (kind_reg == KIND_POWER) begin
      if (frame_pos >= FRAME_LEN) restart_framing();
      if (frame_pos < CHECK_POS) begin
        if (frame_pos == 5'd0 && b != HDR_BYTE0) header_good = 1'b0;
        if (frame_pos == 5'd1 && b != HDR_BYTE1) header_good = 1'b0;
        if (frame_pos >= PAYLOAD_POS) frame_payload[(frame_pos - PAYLOAD_POS) % PAYLOAD_LEN] = b;
        frame_xor = frame_xor ^ b;
        frame_pos = frame_pos + 5'd1;
      end else begin
        good = header_good && frame_xor == b;
        restart_framing();
        if (!good) begin
          emit(ST_BAD, '0, '0, '0, 1'b1);
        end else begin
          for (int k = 0; k <= LAST_CHAN; k++) begin
            emit(ST_CHAN, '0, 3'(k),
                 volts_of({frame_payload[2*k], frame_payload[2*k+1]}, k < BIG_CHANS),
                 k == LAST_CHAN);
          end
        end
      end
    end else begin
      emit(ST_UNKNOWN, '0, '0, '0, 1'b1);
    end
  endtask

  // Monitor: result check, register writes and input transfers, all at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      kind_reg = '0;
      restart_framing();
      foreach (frame_payload[i]) frame_payload[i] = '0;
      settle_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d", out_status);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            n_errors++;
          end
          if (out_record_word !== want.word) begin
            $error("record_word: expected %h, actual %h", want.word, out_record_word);
            n_errors++;
          end
          if (out_channel !== want.channel) begin
            $error("channel: expected %0d, actual %0d", want.channel, out_channel);
            n_errors++;
          end
          if (out_volts_fixed !== want.volts) begin
            $error("volts_fixed: expected %0d, actual %0d", want.volts, out_volts_fixed);
            n_errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_last);
            n_errors++;
          end
        end
      end
      // any write restarts framing
      if (cfg_we) begin
        kind_reg = cfg_message_kind;
        restart_framing();
      end
      if (in_valid && in_ready) begin
        frame_byte(in_rx_byte);
        n_taken++;
      end
      // cycles since the block last had anything to do
      if (pending_results.size() != 0 || (in_valid && in_ready) || cfg_we) settle_count = 0;
      else settle_count++;
    end
  end

  // Driver: next job once the previous transfer is done; waits for quiet before writes
  always @(negedge clk) begin
    logic       nv;
    logic [7:0] nb;
    logic       nwe;
    logic [7:0] nk;
    nv  = in_valid;
    nb  = in_rx_byte;
    nwe = 1'b0;
    nk  = cfg_message_kind;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (n_taken == n_offered) begin
      nv = 1'b0;
      if (jobs.size() != 0) begin
        case (jobs[0].job)
          JOB_BYTE: begin
            if ($urandom_range(99) >= jobs[0].gap_pct) begin
              nv = 1'b1;
              nb = jobs[0].data;
              n_offered <= n_offered + 1;
              cur_stall <= jobs[0].stall_pct;
              if (jobs[0].hold) hold_req <= hold_req + 1;
              void'(jobs.pop_front());
            end
          end
          JOB_KIND: begin
            if (settle_count >= SETTLE_CYCLES) begin
              nwe = 1'b1;
              nk  = jobs[0].data;
              void'(jobs.pop_front());
            end
          end
          JOB_DRAIN: begin
            if (settle_count >= SETTLE_CYCLES) void'(jobs.pop_front());
          end
          default: ;
        endcase
      end
    end
    in_valid         <= nv;
    in_rx_byte       <= nb;
    cfg_we           <= nwe;
    cfg_message_kind <= nk;
  end

  // Receiver: random stalls, plus a long hold-off whenever the driver asks for one
  int unsigned rx_hold_left = 0;
  int unsigned hold_ack     = 0;
  always @(negedge clk) begin
    logic nr;
    if (rx_hold_left != 0) begin
      nr = 1'b0;
      rx_hold_left--;
    end else if (hold_ack != hold_req) begin
      nr           = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
      hold_ack     = hold_req;
    end else begin
      nr = ($urandom_range(99) >= cur_stall);
    end
    out_ready <= nr;
  end

  task automatic push_byte(input logic [7:0] b);
    jobs.push_back('{job: JOB_BYTE, data: b, gap_pct: gen_gap, stall_pct: gen_stall,
                     hold: gen_hold});
    gen_hold = 1'b0;
  endtask

  task automatic push_kind(input logic [7:0] k);
    jobs.push_back('{job: JOB_KIND, data: k, gap_pct: gen_gap, stall_pct: gen_stall,
                     hold: 1'b0});
  endtask

  task automatic push_drain();
    jobs.push_back('{job: JOB_DRAIN, data: 8'd0, gap_pct: gen_gap, stall_pct: gen_stall,
                     hold: 1'b0});
  endtask

  // One power frame, payload bytes 2..15 MSB first, with an optional flaw
  task automatic push_frame(input logic [111:0] pl, input frame_flaw_t flaw);
    logic [7:0] fb [FRAME_LEN];
    logic [7:0] sum;
    fb[0] = HDR_BYTE0;
    fb[1] = HDR_BYTE1;
    if (flaw == FLAW_HDR0) fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_HDR1) fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < PAYLOAD_LEN; i++) fb[i + PAYLOAD_POS] = pl[111 - 8 * i -: 8];
    sum = '0;
    for (int i = 0; i < CHECK_POS; i++) sum = sum ^ fb[i];
    fb[CHECK_POS] = (flaw == FLAW_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    for (int i = 0; i < FRAME_LEN; i++) push_byte(fb[i]);
  endtask

  // Mostly full records, some end markers and near misses
  task automatic push_record();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) begin
      push_byte(END_MARK[23:16]);
      push_byte(END_MARK[15:8]);
      push_byte(END_MARK[7:0]);
    end else if (pick == 1) begin
      push_byte(END_MARK[23:16]);
      push_byte(END_MARK[15:8]);
      push_byte(END_MARK[7:0] ^ 8'($urandom_range(1, 255)));
      repeat (3) push_byte(8'($urandom_range(255)));
    end else begin
      repeat (6) push_byte(8'($urandom_range(255)));
    end
  endtask

  // Mostly good frames; the rest flawed, or noise followed by a resync write
  task automatic push_random_frame();
    logic [111:0] pl;
    int unsigned  pick;
    for (int i = 0; i < 7; i++) begin
      case ($urandom_range(7))
        0:       pl[111 - 16 * i -: 16] = 16'h0000;
        1:       pl[111 - 16 * i -: 16] = 16'hFFFF;
        2:       pl[111 - 16 * i -: 16] = 16'h07FF;
        3:       pl[111 - 16 * i -: 16] = 16'h0800;
        default: pl[111 - 16 * i -: 16] = 16'($urandom);
      endcase
    end
    pick = $urandom_range(9);
    case (pick)
      0: push_frame(pl, FLAW_HDR0);
      1: push_frame(pl, FLAW_HDR1);
      2: push_frame(pl, FLAW_SUM);
      3: begin
        repeat ($urandom_range(1, 16)) push_byte(8'($urandom_range(255)));
        push_kind(KIND_POWER);
      end
      default: push_frame(pl, FLAW_NONE);
    endcase
  endtask

  // Stimulus, reset and end of run
  initial begin
    int unsigned gap_tab[4];
    int unsigned stall_tab[4];
    logic [7:0]  odd_kind;

    gap_tab   = '{0, 60, 0, 14};
    stall_tab = '{0, 0, 60, 14};

    // directed: rejected bytes, end marker, extreme record, extreme channel values
    push_kind(8'd0);
    push_byte(8'h00);
    push_kind(8'hFF);
    push_byte(8'hFF);
    push_kind(KIND_RECORD);
    push_byte(END_MARK[23:16]);
    push_byte(END_MARK[15:8]);
    push_byte(END_MARK[7:0]);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h7F);
    push_kind(KIND_POWER);
    push_frame({16'h0000, 16'hFFFF, 16'h07FF, 16'h0800, 16'hFFFF, 16'h0000, 16'h0801},
               FLAW_NONE);

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      gen_gap   = gap_tab[ph];
      gen_stall = stall_tab[ph];
      push_kind(KIND_RECORD);
      // first phase: long receiver hold-off while records keep coming
      gen_hold = (ph == 0);
      repeat ((ph == 0) ? 10 : 5) push_record();
      push_kind(KIND_POWER);
      for (int f = 0; f < 3; f++) begin
        if (f == 1) push_drain();
        push_random_frame();
      end
      odd_kind = 8'($urandom_range(3, 255));
      if ($urandom_range(3) == 0) odd_kind = 8'd0;
      push_kind(odd_kind);
      push_byte(8'($urandom_range(255)));
      push_byte(8'($urandom_range(255)));
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (jobs.size() != 0) @(posedge clk);
    do @(negedge clk); while (n_taken != n_offered || pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
